// ----- rtl/spsc_pkg.sv -----
package spsc_pkg;

   // Number of servo channels kept in the width store.
   localparam int CHANNELS = 4;
   // The input item carries a fixed number of samples and the result a fixed number of widths.
   localparam int ADC_FIELDS = 4;
   localparam int OUT_FIELDS = 4;
   localparam int ADC_LANES  = (CHANNELS < ADC_FIELDS) ? CHANNELS : ADC_FIELDS;

   localparam int WIDTH_W  = 12;
   localparam int ADC_W    = 10;
   localparam int STEP_W   = 8;
   localparam int SPAN_W   = WIDTH_W + 1;
   localparam int PROD_W   = ADC_W + 1 + SPAN_W;
   localparam int MAG_W    = 22;
   localparam int RECIP_W  = 23;
   localparam int QUOT_W   = WIDTH_W + 1;
   localparam int TARGET_W = WIDTH_W + 2;

   localparam logic [WIDTH_W-1:0] PULSE_MIN_RESET = 12'd500;
   localparam logic [WIDTH_W-1:0] PULSE_MAX_RESET = 12'd2500;
   localparam logic [STEP_W-1:0]  STEP_SIZE_RESET = 8'd10;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET     = 12'd1500;

   // ceil(2^32 / 1023); exact quotient after at most one downward correction.
   localparam logic [RECIP_W-1:0] RECIP_1023  = 23'd4198405;
   localparam int                 RECIP_SHIFT = 32;

   localparam logic OP_ADC   = 1'b0;
   localparam logic OP_NUDGE = 1'b1;

   typedef enum logic [1:0] {
      REG_PULSE_MIN = 2'd0,
      REG_PULSE_MAX = 2'd1,
      REG_STEP_SIZE = 2'd2
   } csr_index_type;

   typedef logic [WIDTH_W-1:0]         width_type;
   typedef logic signed [TARGET_W-1:0] target_type;

   typedef struct packed {
      logic             opcode;
      logic [ADC_W-1:0] adc0;
      logic [ADC_W-1:0] adc1;
      logic [ADC_W-1:0] adc2;
      logic [ADC_W-1:0] adc3;
      logic [1:0]       channel;
      logic             direction;
   } req_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width0;
      logic [WIDTH_W-1:0] width1;
      logic [WIDTH_W-1:0] width2;
      logic [WIDTH_W-1:0] width3;
   } rsp_type;

   // Stage load strobes shared by all lanes.
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
   } lane_ctl_type;

   // What the update stage needs to know about an item besides the targets.
   typedef struct packed {
      logic       nudge;
      logic [1:0] channel;
      logic       direction;
   } op_type;

endpackage

// ----- rtl/spsc_lane.sv -----
// One channel's target mapping: sample * (max - min) / 1023 + min, truncating toward zero.
module spsc_lane (
   input  logic                                clock,
   input  spsc_pkg::lane_ctl_type              ctl,
   input  logic [spsc_pkg::ADC_W-1:0]          sample,
   input  logic [spsc_pkg::WIDTH_W-1:0]        pulse_min,
   input  logic [spsc_pkg::WIDTH_W-1:0]        pulse_max,
   output spsc_pkg::target_type                target
);

   logic signed [spsc_pkg::SPAN_W-1:0] span;
   logic signed [spsc_pkg::PROD_W-1:0] prod;
   logic [spsc_pkg::PROD_W-1:0]        prod_abs;

   logic [spsc_pkg::MAG_W-1:0]  mag1_ff, mag1_in;
   logic                        neg1_ff, neg1_in;

   logic [spsc_pkg::MAG_W+spsc_pkg::RECIP_W-1:0] recip_prod;
   logic [spsc_pkg::QUOT_W-1:0] qest2_ff, qest2_in;
   logic [spsc_pkg::MAG_W-1:0]  mag2_ff;
   logic                        neg2_ff;

   logic [spsc_pkg::RECIP_W-1:0]   back_prod;
   logic [spsc_pkg::QUOT_W-1:0]    quot_fix;
   logic signed [spsc_pkg::TARGET_W-1:0] quot_signed;
   spsc_pkg::target_type target3_ff, target3_in;

   // Stage 1: signed span times the sample, kept as sign and magnitude.
   assign span = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
   assign prod = $signed({1'b0, sample}) * span;
   assign prod_abs = prod[spsc_pkg::PROD_W-1] ? (-prod) : prod;
   assign mag1_in = prod_abs[spsc_pkg::MAG_W-1:0];
   assign neg1_in = prod[spsc_pkg::PROD_W-1];

   // Stage 2: reciprocal multiply gives the quotient or one too many.
   assign recip_prod = mag1_ff * spsc_pkg::RECIP_1023;
   assign qest2_in = recip_prod[spsc_pkg::RECIP_SHIFT +: spsc_pkg::QUOT_W];

   // Stage 3: correct the estimate, restore the sign and add the offset.
   assign back_prod = {qest2_ff, 10'b0} - {10'b0, qest2_ff};
   assign quot_fix  = qest2_ff - {{(spsc_pkg::QUOT_W-1){1'b0}},
                                  (back_prod > {1'b0, mag2_ff})};
   assign quot_signed = neg2_ff ?
                        -$signed({2'b0, quot_fix[spsc_pkg::WIDTH_W-1:0]}) :
                         $signed({2'b0, quot_fix[spsc_pkg::WIDTH_W-1:0]});
   assign target3_in = quot_signed + $signed({2'b0, pulse_min});

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
      end
      if (ctl.s2_load) begin
         qest2_ff <= qest2_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
      end
      if (ctl.s3_load) begin
         target3_ff <= target3_in;
      end
   end

   assign target = target3_ff;

endmodule

// ----- rtl/spsc_update.sv -----
// Merge stage: applies the lane targets or a nudge to the stored widths.
module spsc_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  spsc_pkg::op_type              op,
   input  spsc_pkg::target_type          targets [spsc_pkg::ADC_LANES],
   input  logic [spsc_pkg::WIDTH_W-1:0]  pulse_min,
   input  logic [spsc_pkg::WIDTH_W-1:0]  pulse_max,
   input  logic [spsc_pkg::STEP_W-1:0]   step_size,
   output spsc_pkg::width_type           widths [spsc_pkg::CHANNELS]
);

   localparam int PAD_W = spsc_pkg::WIDTH_W - spsc_pkg::STEP_W;

   spsc_pkg::width_type widths_ff [spsc_pkg::CHANNELS];

   for (genvar ch = 0; ch < spsc_pkg::CHANNELS; ch++) begin : g_chan
      logic [spsc_pkg::WIDTH_W:0]   up_sum;
      logic [spsc_pkg::WIDTH_W:0]   lo_plus_step;
      logic [spsc_pkg::WIDTH_W-1:0] down_diff;
      logic [spsc_pkg::WIDTH_W-1:0] nudged;
      logic [spsc_pkg::WIDTH_W-1:0] slewed;
      logic [spsc_pkg::WIDTH_W-1:0] widths_in;
      logic                         hit;

      assign up_sum       = {1'b0, widths_ff[ch]} + {{(PAD_W+1){1'b0}}, step_size};
      assign lo_plus_step = {1'b0, pulse_min} + {{(PAD_W+1){1'b0}}, step_size};
      assign down_diff    = widths_ff[ch] - {{PAD_W{1'b0}}, step_size};
      assign hit          = (int'(op.channel) == ch);

      // Nudges clamp to the configured range instead of saturating.
      always_comb begin
         nudged = widths_ff[ch];
         if (op.direction) begin
            if (widths_ff[ch] < pulse_max) begin
               nudged = (up_sum > {1'b0, pulse_max}) ? pulse_max
                                                     : up_sum[spsc_pkg::WIDTH_W-1:0];
            end
         end else begin
            if (widths_ff[ch] > pulse_min) begin
               nudged = ({1'b0, widths_ff[ch]} < lo_plus_step) ? pulse_min : down_diff;
            end
         end
      end

      if (ch < spsc_pkg::ADC_LANES) begin : g_slew
         logic signed [spsc_pkg::TARGET_W-1:0] width_s;
         assign width_s = $signed({2'b0, widths_ff[ch]});
         always_comb begin
            slewed = widths_ff[ch];
            if (targets[ch] > width_s) begin
               slewed = up_sum[spsc_pkg::WIDTH_W] ? '1 : up_sum[spsc_pkg::WIDTH_W-1:0];
            end else if (targets[ch] < width_s) begin
               slewed = ({1'b0, widths_ff[ch]} < {{(PAD_W+1){1'b0}}, step_size}) ?
                        '0 : down_diff;
            end
         end
      end else begin : g_no_slew
         assign slewed = widths_ff[ch];
      end

      always_comb begin
         widths_in = widths_ff[ch];
         if (load) begin
            if (op.nudge == spsc_pkg::OP_NUDGE) begin
               if (hit) begin
                  widths_in = nudged;
               end
            end else begin
               widths_in = slewed;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            widths_ff[ch] <= spsc_pkg::WIDTH_RESET;
         end else begin
            widths_ff[ch] <= widths_in;
         end
      end

      assign widths[ch] = widths_ff[ch];
   end

endmodule

// ----- rtl/servo_pulse_slew_controller_top.sv -----
// Servo pulse slew controller.
//
// The req channel transfers one item per accepted cycle: either an ADC frame of four
// 10-bit samples (opcode 0) or a nudge of one channel up or down (opcode 1). Each
// item produces exactly one transfer on the rsp channel carrying all four pulse
// widths as they stand after that item. Channels beyond the configured count read
// as zero. The csr port writes pulse_min, pulse_max and step_size; writes are
// expected only while no item is in flight.
//
// The rsp_valid flag rises once an item has passed the lane stages and the merge stage.
// Throughput is one item per cycle while rsp is not stalled: four identical lanes map
// the samples to targets through a three-stage pipeline (product, reciprocal
// multiply by 1/1023, correction and offset), and a merge stage moves the stored
// widths and loads the response register.
//
// The stored widths are the response register: they change only when an item
// enters the response stage, so a stalled rsp payload holds. Bubbles in the lane
// pipeline are squeezed out while rsp is stalled; req_stall rises only once every
// stage is full. Reset clears the pipeline, the widths to 1500 and the registers
// to their defaults.
module servo_pulse_slew_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  spsc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output spsc_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [spsc_pkg::WIDTH_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [spsc_pkg::WIDTH_W-1:0] pulse_min_ff;
   logic [spsc_pkg::WIDTH_W-1:0] pulse_max_ff;
   logic [spsc_pkg::STEP_W-1:0]  step_size_ff;

   // Pipeline occupancy.
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Item kind and nudge fields travel beside the lane data.
   spsc_pkg::op_type op1_ff, op2_ff, op3_ff, op_in;

   spsc_pkg::lane_ctl_type ctl;
   logic                   out_load;
   logic                   accept;

   logic [spsc_pkg::ADC_W-1:0] adc_sample [spsc_pkg::ADC_FIELDS];
   spsc_pkg::target_type       targets    [spsc_pkg::ADC_LANES];
   spsc_pkg::width_type        widths     [spsc_pkg::CHANNELS];
   spsc_pkg::width_type        out_w      [spsc_pkg::OUT_FIELDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= spsc_pkg::PULSE_MIN_RESET;
         pulse_max_ff <= spsc_pkg::PULSE_MAX_RESET;
         step_size_ff <= spsc_pkg::STEP_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            spsc_pkg::REG_PULSE_MIN: pulse_min_ff <= csr_wdata;
            spsc_pkg::REG_PULSE_MAX: pulse_max_ff <= csr_wdata;
            spsc_pkg::REG_STEP_SIZE: step_size_ff <= csr_wdata[spsc_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage advances when the stage after it is empty or advancing itself.
   assign out_load    = v3_ff && (!rsp_valid_ff || !rsp_stall);
   assign ctl.s3_load = v2_ff && (!v3_ff || out_load);
   assign ctl.s2_load = v1_ff && (!v2_ff || ctl.s3_load);
   assign req_stall   = v1_ff && !ctl.s2_load;
   assign accept      = req_valid && !req_stall;
   assign ctl.s1_load = accept;

   always_comb begin
      v1_in = ctl.s1_load || (v1_ff && !ctl.s2_load);
      v2_in = ctl.s2_load || (v2_ff && !ctl.s3_load);
      v3_in = ctl.s3_load || (v3_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   assign op_in.nudge     = (req_data.opcode == spsc_pkg::OP_NUDGE);
   assign op_in.channel   = req_data.channel;
   assign op_in.direction = req_data.direction;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         op1_ff <= op_in;
      end
      if (ctl.s2_load) begin
         op2_ff <= op1_ff;
      end
      if (ctl.s3_load) begin
         op3_ff <= op2_ff;
      end
   end

   assign adc_sample[0] = req_data.adc0;
   assign adc_sample[1] = req_data.adc1;
   assign adc_sample[2] = req_data.adc2;
   assign adc_sample[3] = req_data.adc3;

   for (genvar i = 0; i < spsc_pkg::ADC_LANES; i++) begin : g_lane
      spsc_lane u_lane (
         .clock     (clock),
         .ctl       (ctl),
         .sample    (adc_sample[i]),
         .pulse_min (pulse_min_ff),
         .pulse_max (pulse_max_ff),
         .target    (targets[i])
      );
   end

   spsc_update u_update (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .op        (op3_ff),
      .targets   (targets),
      .pulse_min (pulse_min_ff),
      .pulse_max (pulse_max_ff),
      .step_size (step_size_ff),
      .widths    (widths)
   );

   // Result fields past the channel count read as zero.
   for (genvar i = 0; i < spsc_pkg::OUT_FIELDS; i++) begin : g_out
      if (i < spsc_pkg::CHANNELS) begin : g_used
         assign out_w[i] = widths[i];
      end else begin : g_unused
         assign out_w[i] = '0;
      end
   end

   assign rsp_data.width0 = out_w[0];
   assign rsp_data.width1 = out_w[1];
   assign rsp_data.width2 = out_w[2];
   assign rsp_data.width3 = out_w[3];
   assign rsp_valid       = rsp_valid_ff;

endmodule

// ----- rtl/spsc_checker.sv -----
module spsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input spsc_pkg::rsp_type rsp_data
);

   // A waiting response keeps its widths until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // Nothing can reach the response stage sooner than the pipeline depth after reset.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("rsp_valid too soon after reset");

   // With the response stage empty every stage can drain, so req is never held off.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall high while rsp stage is empty");

   // A response cannot appear in the cycle right after an idle, empty pipeline.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) ##1
      !rsp_valid && !(req_valid && !req_stall) ##1
      !rsp_valid && !(req_valid && !req_stall) ##1
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("rsp transfer without a req transfer");

endmodule

bind servo_pulse_slew_controller_top spsc_checker u_spsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
